// ===== rtl/dnsle_pkg.sv =====
package dnsle_pkg;

  localparam int unsigned MaxLabelDef = 62;
  localparam int unsigned PosW        = 10;
  localparam logic [7:0]  DotChar     = 8'h2E;
  localparam logic [PosW-1:0] PosMax  = '1;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_name;
  } in_req_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [PosW-1:0] position;
    logic            label_overflow;
    logic            last;
  } out_req_t;

endpackage

// ===== rtl/dnsle_label_mem.sv =====
module dnsle_label_mem import dnsle_pkg::*; #(
  parameter int unsigned Depth = MaxLabelDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dnsle_ctrl.sv =====
module dnsle_ctrl import dnsle_pkg::*; #(
  parameter int unsigned MaxLabel = MaxLabelDef,
  parameter int unsigned AddrW    = (MaxLabel > 1) ? $clog2(MaxLabel) : 1,
  parameter int unsigned LenW     = $clog2(MaxLabel + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_req_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_req_t         out_data_o,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StLen  = 4'b0010,
    StData = 4'b0100,
    StTerm = 4'b1000
  } state_e;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxLabel);

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            eon_q, eon_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  out_req_t        out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            in_acc;
  logic            slot_free;
  logic [PosW-1:0] pos_inc;
  logic            last_byte;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pos_inc    = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
  assign last_byte  = (LenW'(rd_addr_q) + LenW'(1)) == len_q;

  assign wr_en_o   = in_acc && !in_data_i.end_of_name && (in_data_i.ch != DotChar)
                     && (len_q < MaxLen);
  assign wr_addr_o = AddrW'(len_q);
  assign wr_data_o = in_data_i.ch;
  // read address is taken from rd_addr_d so the registered read data matches rd_addr_q
  assign rd_addr_o = rd_addr_d;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    eon_d       = eon_q;
    rd_addr_d   = rd_addr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.end_of_name || (in_data_i.ch == DotChar)) begin
            eon_d     = in_data_i.end_of_name;
            rd_addr_d = '0;
            state_d   = StLen;
          end else if (len_q < MaxLen) begin
            len_d = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      StLen: begin
        if (slot_free) begin
          out_d       = '{out_byte: 8'(len_q), position: pos_q,
                          label_overflow: ovf_q, last: 1'b0};
          out_valid_d = 1'b1;
          pos_d       = pos_inc;
          if (len_q == '0) begin
            state_d = eon_q ? StTerm : StIdle;
          end else begin
            state_d = StData;
          end
        end
      end
      StData: begin
        if (slot_free) begin
          out_d       = '{out_byte: rd_data_i, position: pos_q,
                          label_overflow: ovf_q, last: 1'b0};
          out_valid_d = 1'b1;
          pos_d       = pos_inc;
          if (last_byte) begin
            len_d   = '0;
            state_d = eon_q ? StTerm : StIdle;
          end else begin
            rd_addr_d = rd_addr_q + AddrW'(1);
          end
        end
      end
      StTerm: begin
        if (slot_free) begin
          out_d       = '{out_byte: 8'h00, position: pos_q,
                          label_overflow: ovf_q, last: 1'b1};
          out_valid_d = 1'b1;
          pos_d       = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if ((state_q == StLen) && slot_free && (len_q == '0)) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      eon_q       <= 1'b0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      eon_q       <= eon_d;
      rd_addr_q   <= rd_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/dns_name_label_encoder.sv =====
// Channel   Direction  Payload    Handshake
// in        input      in_req_t   in_valid_i / in_stall_o
// out       output     out_req_t  out_valid_o / out_stall_i
//
// A plain character is accepted and written to the label store while it has room.
// A dot or end of name holds the input while its length byte and label bytes go out
// (and terminator), one byte a cycle unless stalled, paced by the single read port.
// Reset clears the label length, position and overflow flag; the store is not cleared.
// A stall on the output freezes the byte sequencer; the input stays stalled meanwhile.
module dns_name_label_encoder import dnsle_pkg::*; #(
  parameter int unsigned MaxLabel = MaxLabelDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_data_o
);

  localparam int unsigned AddrW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
  localparam int unsigned LenW  = $clog2(MaxLabel + 1);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  dnsle_ctrl #(
    .MaxLabel (MaxLabel),
    .AddrW    (AddrW),
    .LenW     (LenW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  dnsle_label_mem #(
    .Depth (MaxLabel),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// ===== tb/dnsle_wire_checker.sv =====
module dnsle_wire_checker import dnsle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_req_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_req_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LabelCap = MaxLabelDef;

  logic [7:0]      label_bytes [LabelCap];
  logic [5:0]      label_len  = '0;
  logic [PosW-1:0] wire_pos   = '0;
  logic            trunc_seen = 1'b0;
  logic            req_seen   = 1'b0;
  out_req_t        wire_q [$];
  int unsigned     fails  = 0;
  int unsigned     queued = 0;

  assign fail_count_o = fails;
  assign pending_o    = queued;

  task automatic report_fail(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  function automatic void emit_byte(input logic [7:0] b, input logic term);
    out_req_t r;
    r.out_byte       = b;
    r.position       = wire_pos;
    r.label_overflow = trunc_seen;
    r.last           = term;
    wire_q.push_back(r);
    if (wire_pos != PosMax) wire_pos++;
  endfunction

  function automatic void flush_label();
    int i;
    emit_byte({2'b00, label_len}, 1'b0);
    for (i = 0; i < label_len; i++) emit_byte(label_bytes[i], 1'b0);
    label_len = '0;
  endfunction

  function automatic void encode_request(input in_req_t r);
    if (r.end_of_name) begin
      flush_label();
      emit_byte(8'h00, 1'b1);
      wire_pos = '0;
    end else if (r.ch == DotChar) begin
      flush_label();
    end else if (label_len < LabelCap) begin
      label_bytes[label_len] = r.ch;
      label_len++;
    end else begin
      trunc_seen = 1'b1;
    end
  endfunction

  // The sender holds a request steady until taken, so the bytes are predicted
  // when it first shows up: a flush may be emitted while the dot is still stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      label_len  = '0;
      wire_pos   = '0;
      trunc_seen = 1'b0;
      req_seen   = 1'b0;
      wire_q.delete();
    end else begin
      if (in_valid_i && !req_seen) encode_request(in_data_i);
      req_seen = in_valid_i && in_stall_i;
      if (out_valid_i && !out_stall_i) begin
        if (wire_q.size() == 0) begin
          report_fail($sformatf("unexpected byte %02h at pos %0d",
                                out_data_i.out_byte, out_data_i.position));
        end else begin
          want = wire_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            report_fail($sformatf("pos %0d byte: got %02h want %02h", want.position,
                                  out_data_i.out_byte, want.out_byte));
          if (out_data_i.position !== want.position)
            report_fail($sformatf("position: got %0d want %0d",
                                  out_data_i.position, want.position));
          if (out_data_i.label_overflow !== want.label_overflow)
            report_fail($sformatf("pos %0d overflow: got %b want %b", want.position,
                                  out_data_i.label_overflow, want.label_overflow));
          if (out_data_i.last !== want.last)
            report_fail($sformatf("pos %0d last: got %b want %b", want.position,
                                  out_data_i.last, want.last));
        end
      end
    end
    queued = wire_q.size();
  end

endmodule

// ===== tb/tb_dns_name_label_encoder.sv =====
module tb_dns_name_label_encoder;
  import dnsle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems   = 12;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_req_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_req_t    out_data_o;

  logic        calm      = 1'b0;
  logic        hold_arm  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned sent      = 0;
  int unsigned fails;
  int unsigned pending;

  dns_name_label_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  dnsle_wire_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Output side: random stalls, plus one long hold-off once armed.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  function automatic logic [7:0] draw_name_char(input bit noisy);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (!noisy || $urandom_range(0, 19) != 0) begin
      while (b == DotChar) b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic push_request(input logic [7:0] c, input logic eon);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{ch: c, end_of_name: eon};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_label(input int unsigned len, input bit noisy);
    int unsigned j;
    for (j = 0; j < len; j++) push_request(draw_name_char(noisy), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned n_labels;
    int unsigned len;
    int unsigned k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty name, leading and doubled dots, byte extremes, empty final label
    push_request(8'hFF, 1'b1);
    push_request(DotChar, 1'b0);
    push_request(8'h00, 1'b0);
    push_request(8'hFF, 1'b0);
    push_request(8'h2D, 1'b0);
    push_request(8'h2F, 1'b0);
    push_request(DotChar, 1'b0);
    push_request(DotChar, 1'b0);
    push_request(8'h7F, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'h55, 1'b0);
    push_request(8'hAA, 1'b0);
    push_request(DotChar, 1'b1);
    push_request(8'h01, 1'b0);
    push_request(DotChar, 1'b0);
    push_request(8'h00, 1'b1);

    sent = 0;
    while (sent < RandItems) begin
      calm <= (sent >= 4 && sent < 8);
      if ($urandom_range(0, 7) == 0) push_request(DotChar, 1'b0);
      n_labels = $urandom_range(1, 3);
      for (k = 0; k < n_labels; k++) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        send_label(len, 1'b1);
        if (k + 1 < n_labels || $urandom_range(0, 9) == 0) push_request(DotChar, 1'b0);
      end
      push_request(8'($urandom_range(0, 255)), 1'b1);
    end

    // long receiver hold-off while requests keep coming
    calm     <= 1'b1;
    hold_arm <= 1'b1;
    send_label(4, 1'b0);
    push_request(DotChar, 1'b0);
    send_label(4, 1'b0);
    push_request(8'($urandom_range(0, 255)), 1'b1);

    // truncated label with no idling; overflow stays set from here on
    send_label(MaxLabelDef + 2, 1'b0);
    push_request(DotChar, 1'b0);
    send_label(2, 1'b0);
    push_request(8'($urandom_range(0, 255)), 1'b1);
    calm <= 1'b0;
    send_label(2, 1'b1);
    push_request(8'($urandom_range(0, 255)), 1'b1);

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
